FILE: design/assert_macros.svh
// Assertion helpers shared by the RTL. All checks are clocked on clk and
// are held off while the synchronous reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge.
`define SIS_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that the consequent holds in the same cycle as the antecedent.
`define SIS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define SIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/sis_pkg.sv
package sis_pkg;

  localparam int unsigned FSPI_W       = 13;
  localparam int unsigned STEPS_W      = 17;
  localparam int unsigned CFG_INDEX_W  = 2;
  localparam int unsigned CFG_DATA_W   = 13;
  localparam int unsigned MODE_W       = 3;
  localparam int unsigned TLEN_W       = 5;
  localparam int unsigned SHIFT_W      = 3;
  localparam logic [FSPI_W-1:0] FSPI_MAX = 13'd4096;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_START = 2'd2
  } opcode_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_STEP_MODE    = 2'd0,
    CFG_FULL_STEPS   = 2'd1,
    CFG_TABLE_LENGTH = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD_OLD,
    ST_RD_NEW,
    ST_DIV
  } state_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  table_address;
    logic [23:0] table_value;
  } in_item_t;

  typedef struct packed {
    logic       step_pulse;
    logic       direction;
    logic [3:0] table_index;
    logic       interval_done;
    logic [2:0] microstep_pins;
  } out_item_t;

  // MS1/MS2/MS3 levels per step mode; unused modes run as full step.
  function automatic logic [2:0] mode_pins(input logic [MODE_W-1:0] mode);
    logic [2:0] pins;
    unique case (mode)
      3'd1:    pins = 3'b001;
      3'd2:    pins = 3'b010;
      3'd3:    pins = 3'b011;
      3'd4:    pins = 3'b111;
      default: pins = 3'b000;
    endcase
    return pins;
  endfunction

  // log2 of the microstep factor.
  function automatic logic [SHIFT_W-1:0] mode_shift(input logic [MODE_W-1:0] mode);
    logic [SHIFT_W-1:0] sh;
    unique case (mode)
      3'd1:    sh = 3'd1;
      3'd2:    sh = 3'd2;
      3'd3:    sh = 3'd3;
      3'd4:    sh = 3'd4;
      default: sh = 3'd0;
    endcase
    return sh;
  endfunction

endpackage

FILE: design/sis_divider.sv
module sis_divider #(
  parameter int unsigned DIVIDEND_W = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [DIVIDEND_W-1:0]          dividend,
  input  logic [sis_pkg::FSPI_W-1:0]     divisor,
  output logic                           done,
  output logic [DIVIDEND_W-1:0]          quotient
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIVIDEND_W - 1);

  logic                           busy_r;
  logic                           done_r;
  logic [CNT_W-1:0]               cnt_r;
  logic [sis_pkg::FSPI_W-1:0]     rem_r;
  logic [sis_pkg::FSPI_W-1:0]     div_r;
  logic [DIVIDEND_W-1:0]          quo_r;
  logic [sis_pkg::FSPI_W:0]       trial;
  logic                           fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  assign trial = {rem_r, quo_r[DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      div_r <= divisor;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= fits ? sis_pkg::FSPI_W'(trial - {1'b0, div_r})
                    : trial[sis_pkg::FSPI_W-1:0];
      quo_r <= {quo_r[DIVIDEND_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: design/stepper_interval_step_scheduler.sv
// A tick that stays inside its interval, a table write or an unused opcode
// returns its result in the cycle after acceptance; a start passes through
// RD_NEW and DIV, and a tick that ends an interval through RD_OLD, RD_NEW and DIV.
// Throughput: one transaction at a time, with the input held off while the
// one-bit-per-cycle restoring divider computes the step spacing.
// Reset (synchronous, rst_n low): schedule state cleared, direction high, table undefined.
module stepper_interval_step_scheduler #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned TIME_WIDTH  = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  sis_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output sis_pkg::out_item_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sis_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [sis_pkg::CFG_DATA_W-1:0]      cfg_data
);

`include "assert_macros.svh"

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned AW    = (IDX_W > 4) ? IDX_W : 4;
  // Width for length and index compares: holds TABLE_DEPTH and a 5-bit length.
  localparam int unsigned CW    = (IDX_W + 1 > 5) ? IDX_W + 1 : 5;
  localparam logic [AW:0]   DEPTH_A = (AW + 1)'(TABLE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  // Configuration registers.
  logic [sis_pkg::MODE_W-1:0]   step_mode_r;
  logic [sis_pkg::FSPI_W-1:0]   full_steps_r;
  logic [sis_pkg::TLEN_W-1:0]   table_length_r;

  // Schedule state. rel_time_r is elapsed time minus interval start time.
  sis_pkg::state_t              state_r, state_nxt;
  logic [31:0]                  rel_time_r, rel_time_nxt;
  logic [TIME_WIDTH-1:0]        next_step_time_r, next_step_time_nxt;
  logic [TIME_WIDTH-1:0]        step_spacing_r, step_spacing_nxt;
  logic [sis_pkg::STEPS_W-1:0]  steps_taken_r, steps_taken_nxt;
  logic [IDX_W-1:0]             cur_index_r, cur_index_nxt;
  logic                         descending_r, descending_nxt;
  logic                         direction_r, direction_nxt;
  logic                         pulse_r, pulse_nxt;
  logic                         iv_done_r, iv_done_nxt;
  logic                         out_valid_r, out_valid_nxt;
  sis_pkg::out_item_t           out_data_r, out_data_nxt;

  // Interval table memory.
  logic [TIME_WIDTH-1:0]        table_mem [TABLE_DEPTH];
  logic [TIME_WIDTH-1:0]        mem_rdata_r;
  logic                         mem_re;
  logic [IDX_W-1:0]             mem_raddr;
  logic                         mem_we;
  logic [AW-1:0]                wr_addr;

  // Derived configuration values.
  logic [sis_pkg::FSPI_W-1:0]   full_steps;
  logic [sis_pkg::SHIFT_W-1:0]  ustep_shift;
  logic [sis_pkg::STEPS_W-1:0]  steps_per_iv;
  logic [CW-1:0]                tlen_ext;
  logic [CW-1:0]                used_len;
  logic [2:0]                   pins;

  logic                         in_fire;
  logic                         div_start;
  logic                         div_done;
  logic [TIME_WIDTH-1:0]        div_quot;

  assign in_fire   = in_valid && in_ready;
  assign in_ready  = (state_r == sis_pkg::ST_IDLE) && (!out_valid_r || out_ready);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------
  // Configuration port: writes beyond the register list are dropped.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_mode_r    <= '0;
      full_steps_r   <= sis_pkg::FSPI_W'(1);
      table_length_r <= sis_pkg::TLEN_W'(16);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sis_pkg::CFG_STEP_MODE:    step_mode_r    <= cfg_data[sis_pkg::MODE_W-1:0];
        sis_pkg::CFG_FULL_STEPS:   full_steps_r   <= cfg_data;
        sis_pkg::CFG_TABLE_LENGTH: table_length_r <= cfg_data[sis_pkg::TLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp full steps to 1..4096 and the table length to 1..TABLE_DEPTH.
  always_comb begin
    if (full_steps_r == '0) begin
      full_steps = sis_pkg::FSPI_W'(1);
    end else if (full_steps_r > sis_pkg::FSPI_MAX) begin
      full_steps = sis_pkg::FSPI_MAX;
    end else begin
      full_steps = full_steps_r;
    end
    tlen_ext = CW'(table_length_r);
    if (tlen_ext == '0) begin
      used_len = CW'(1);
    end else if (tlen_ext > DEPTH_C) begin
      used_len = DEPTH_C;
    end else begin
      used_len = tlen_ext;
    end
  end

  // The microstep factor is a power of two, so steps per interval is a shift.
  assign ustep_shift  = sis_pkg::mode_shift(step_mode_r);
  assign steps_per_iv = sis_pkg::STEPS_W'(full_steps) << ustep_shift;
  assign pins         = sis_pkg::mode_pins(step_mode_r);

  // ---------------------------------------------------------------------
  // Table memory: one write port from the input channel, one registered read
  // port owned by the sequencer. Writes happen only for a write opcode in IDLE and
  // reads only for ticks and starts (in IDLE and RD_OLD), so the two never collide.
  // ---------------------------------------------------------------------
  assign wr_addr = AW'(in_data.table_address);
  assign mem_we  = in_fire && (in_data.opcode == sis_pkg::OP_WRITE)
                   && ({1'b0, wr_addr} < DEPTH_A);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[wr_addr[IDX_W-1:0]] <= TIME_WIDTH'(in_data.table_value);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_rdata_r <= table_mem[mem_raddr];
    end
  end

  // Step spacing = entry / (full_steps << shift) = (entry >> shift) / full_steps.
  sis_divider #(
    .DIVIDEND_W (TIME_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mem_rdata_r >> ustep_shift),
    .divisor  (full_steps),
    .done     (div_done),
    .quotient (div_quot)
  );

  // ---------------------------------------------------------------------
  // Sequencer state and schedule registers.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= sis_pkg::ST_IDLE;
      rel_time_r       <= '0;
      next_step_time_r <= '0;
      step_spacing_r   <= '0;
      steps_taken_r    <= '0;
      cur_index_r      <= '0;
      descending_r     <= 1'b0;
      direction_r      <= 1'b1;
      pulse_r          <= 1'b0;
      iv_done_r        <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      rel_time_r       <= rel_time_nxt;
      next_step_time_r <= next_step_time_nxt;
      step_spacing_r   <= step_spacing_nxt;
      steps_taken_r    <= steps_taken_nxt;
      cur_index_r      <= cur_index_nxt;
      descending_r     <= descending_nxt;
      direction_r      <= direction_nxt;
      pulse_r          <= pulse_nxt;
      iv_done_r        <= iv_done_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // Tick flow:   IDLE -> (interval ends) RD_OLD -> RD_NEW -> DIV -> IDLE
  // Start flow:  IDLE -> RD_NEW -> DIV -> IDLE
  // RD_OLD retires the finished interval (needs its entry) and reads the new index,
  // RD_NEW starts the divide on the entry of the new index, DIV computes the new spacing.
  always_comb begin
    logic [31:0]             rel_inc;
    logic                    step_now;
    logic [TIME_WIDTH:0]     nst_sum;
    logic [sis_pkg::STEPS_W-1:0] steps_upd;
    logic [CW-1:0]           idx_c;

    state_nxt          = state_r;
    rel_time_nxt       = rel_time_r;
    next_step_time_nxt = next_step_time_r;
    step_spacing_nxt   = step_spacing_r;
    steps_taken_nxt    = steps_taken_r;
    cur_index_nxt      = cur_index_r;
    descending_nxt     = descending_r;
    direction_nxt      = direction_r;
    pulse_nxt          = pulse_r;
    iv_done_nxt        = iv_done_r;
    out_valid_nxt      = out_valid_r && !out_ready;
    out_data_nxt       = out_data_r;
    mem_re             = 1'b0;
    mem_raddr          = cur_index_r;
    div_start          = 1'b0;

    rel_inc   = rel_time_r + 32'd1;
    step_now  = rel_inc >= 32'(next_step_time_r);
    nst_sum   = {1'b0, next_step_time_r} + {1'b0, step_spacing_r};
    steps_upd = step_now ? steps_taken_r + 1'b1 : steps_taken_r;
    idx_c     = CW'(cur_index_r);

    unique case (state_r)
      sis_pkg::ST_IDLE: begin
        if (in_fire) begin
          // Default result: no pulse, no interval end, current position.
          out_data_nxt.step_pulse     = 1'b0;
          out_data_nxt.direction      = direction_r;
          out_data_nxt.table_index    = 4'(cur_index_r);
          out_data_nxt.interval_done  = 1'b0;
          out_data_nxt.microstep_pins = pins;
          unique case (in_data.opcode)
            sis_pkg::OP_TICK: begin
              rel_time_nxt    = rel_inc;
              steps_taken_nxt = steps_upd;
              if (step_now) begin
                // Saturate the next step time at the time field's maximum.
                next_step_time_nxt = nst_sum[TIME_WIDTH] ? '1 : nst_sum[TIME_WIDTH-1:0];
              end
              if (steps_upd >= steps_per_iv) begin
                // Interval complete: fetch its entry to retire it.
                mem_re      = 1'b1;
                mem_raddr   = cur_index_r;
                pulse_nxt   = step_now;
                iv_done_nxt = 1'b1;
                state_nxt   = sis_pkg::ST_RD_OLD;
              end else begin
                out_data_nxt.step_pulse = step_now;
                out_valid_nxt           = 1'b1;
              end
            end
            sis_pkg::OP_START: begin
              cur_index_nxt  = '0;
              descending_nxt = 1'b0;
              rel_time_nxt   = '0;
              mem_re         = 1'b1;
              mem_raddr      = '0;
              pulse_nxt      = 1'b0;
              iv_done_nxt    = 1'b0;
              state_nxt      = sis_pkg::ST_RD_NEW;
            end
            default: begin
              // Table write (memory side above) and unused opcode.
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      sis_pkg::ST_RD_OLD: begin
        // Move the interval start forward by the finished entry.
        rel_time_nxt = rel_time_r - 32'(mem_rdata_r);
        // Ping-pong the index; flip direction when it would go below zero.
        if (idx_c >= used_len) begin
          cur_index_nxt  = IDX_W'(used_len - CW'(1));
          descending_nxt = 1'b1;
        end else if (descending_r) begin
          if (cur_index_r == '0) begin
            direction_nxt  = !direction_r;
            descending_nxt = 1'b0;
          end else begin
            cur_index_nxt = cur_index_r - 1'b1;
          end
        end else begin
          if (idx_c + CW'(1) >= used_len) begin
            descending_nxt = 1'b1;
          end else begin
            cur_index_nxt = cur_index_r + 1'b1;
          end
        end
        mem_re    = 1'b1;
        mem_raddr = cur_index_nxt;
        state_nxt = sis_pkg::ST_RD_NEW;
      end

      sis_pkg::ST_RD_NEW: begin
        div_start = 1'b1;
        state_nxt = sis_pkg::ST_DIV;
      end

      sis_pkg::ST_DIV: begin
        if (div_done) begin
          step_spacing_nxt            = div_quot;
          next_step_time_nxt          = div_quot;
          steps_taken_nxt             = '0;
          out_data_nxt.step_pulse     = pulse_r;
          out_data_nxt.direction      = direction_r;
          out_data_nxt.table_index    = 4'(cur_index_r);
          out_data_nxt.interval_done  = iv_done_r;
          out_data_nxt.microstep_pins = pins;
          out_valid_nxt               = 1'b1;
          state_nxt                   = sis_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = sis_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `SIS_ASSERT_IMP(a_div_done_in_div, div_done, state_r == sis_pkg::ST_DIV,
                  "divider finished outside the divide state")
  `SIS_ASSERT_NEXT(a_write_result_next, in_fire && in_data.opcode == sis_pkg::OP_WRITE,
                   out_valid_r && state_r == sis_pkg::ST_IDLE,
                   "table write did not return its result in one cycle")
  `SIS_ASSERT_NEXT(a_load_spacing, state_r == sis_pkg::ST_DIV && div_done,
                   next_step_time_r == step_spacing_r && steps_taken_r == '0,
                   "new interval not loaded with its spacing")
  `SIS_ASSERT_IMP(a_index_in_table, state_r == sis_pkg::ST_IDLE,
                  CW'(cur_index_r) < DEPTH_C,
                  "table index beyond table depth")

endmodule

FILE: bench/stepper_interval_step_scheduler_tb.sv
`timescale 1ns / 100ps

module stepper_interval_step_scheduler_tb;

  localparam int unsigned TABLE_DEPTH  = 16;
  localparam int unsigned TIME_WIDTH   = 24;
  localparam int unsigned RANDOM_ITEMS = 650;
  // Longest item is a tick that closes an interval.
  localparam int unsigned DRAIN_CYCLES = TIME_WIDTH + 8;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned STALL_LIMIT  = 3000;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

  // Result of any write, start or unused opcode straight out of reset.
  localparam sis_pkg::out_item_t AFTER_RESET = '{step_pulse: 1'b0, direction: 1'b1,
                                                 table_index: 4'd0, interval_done: 1'b0,
                                                 microstep_pins: 3'b000};

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  sis_pkg::in_item_t in_data;
  logic out_valid;
  logic out_ready;
  sis_pkg::out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [sis_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [sis_pkg::CFG_DATA_W-1:0] cfg_data;

  stepper_interval_step_scheduler #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .TIME_WIDTH (TIME_WIDTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Schedule predictor: its own copy of the interval table, the timing
  // state and the three registers.
  // ---------------------------------------------------------------------
  logic [TIME_WIDTH-1:0] dur_mem [TABLE_DEPTH];
  logic [31:0]           now_us          = '0;
  logic [31:0]           interval_origin = '0;
  logic [TIME_WIDTH-1:0] next_step_due   = '0;
  logic [TIME_WIDTH-1:0] step_gap        = '0;
  logic [sis_pkg::STEPS_W-1:0] steps_done = '0;
  logic [3:0]            cur_index       = '0;
  logic                  counting_down   = 1'b0;
  logic                  dir_level       = 1'b1;
  logic [2:0]            mode_q          = 3'd0;
  logic [12:0]           full_steps_q    = 13'd1;
  logic [4:0]            length_q        = 5'd16;

  sis_pkg::out_item_t pending_results [$];

  int unsigned error_count     = 0;
  int unsigned items_in        = 0;
  int unsigned results_checked = 0;
  int unsigned reg_writes      = 0;
  int unsigned intervals_seen  = 0;
  int unsigned reversals       = 0;
  int unsigned random_sent     = 0;
  int unsigned phase_count     = 0;
  int unsigned quiet_cycles    = 0;

  // Stimulus-side controls shared with the receiver process.
  bit        no_idle      = 1'b0;
  bit        hold_request = 1'b0;
  bit        drv_has_exp;
  sis_pkg::out_item_t drv_exp;

  // Microsteps per interval: full steps clamped to 1..4096, scaled by mode.
  function automatic int unsigned interval_steps(input logic [2:0] mode,
                                                 input logic [12:0] fsi);
    int unsigned f;
    f = fsi;
    if (f == 0) f = 1;
    if (f > 4096) f = 4096;
    case (mode)
      3'd1, 3'd2, 3'd3, 3'd4: return f << mode;
      default:                return f;
    endcase
  endfunction

  function automatic logic [2:0] pins_for(input logic [2:0] mode);
    case (mode)
      3'd1:    return 3'b001;
      3'd2:    return 3'b010;
      3'd3:    return 3'b011;
      3'd4:    return 3'b111;
      default: return 3'b000;
    endcase
  endfunction

  function automatic int unsigned active_length();
    int unsigned n;
    n = length_q;
    if (n == 0) n = 1;
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    return n;
  endfunction

  task automatic load_interval();
    step_gap      = TIME_WIDTH'(dur_mem[cur_index] / interval_steps(mode_q, full_steps_q));
    next_step_due = step_gap;
    steps_done    = '0;
  endtask

  // Ping-pong through the entries in use; flip direction at the bottom.
  task automatic move_index();
    int unsigned len;
    len = active_length();
    if (cur_index >= len) begin
      // Length shrank under the index: jump to the last entry, count down.
      cur_index     = 4'(len - 1);
      counting_down = 1'b1;
    end else if (counting_down) begin
      if (cur_index == 0) begin
        dir_level     = ~dir_level;
        counting_down = 1'b0;
        reversals++;
      end else begin
        cur_index = cur_index - 1'b1;
      end
    end else if (cur_index + 1 >= len) begin
      counting_down = 1'b1;
    end else begin
      cur_index = cur_index + 1'b1;
    end
  endtask

  task automatic schedule_step(input sis_pkg::in_item_t it, output sis_pkg::out_item_t res);
    logic [31:0]         since_origin;
    logic [TIME_WIDTH:0] bumped;
    res = '0;
    case (it.opcode)
      sis_pkg::OP_TICK: begin
        now_us       = now_us + 1;
        since_origin = now_us - interval_origin;
        if (since_origin >= next_step_due) begin
          // Saturate the due time instead of wrapping it.
          bumped          = next_step_due + step_gap;
          next_step_due   = bumped[TIME_WIDTH] ? TIME_MAX : bumped[TIME_WIDTH-1:0];
          steps_done      = steps_done + 1'b1;
          res.step_pulse  = 1'b1;
        end
        if (steps_done >= interval_steps(mode_q, full_steps_q)) begin
          interval_origin   = interval_origin + dur_mem[cur_index];
          move_index();
          load_interval();
          res.interval_done = 1'b1;
          intervals_seen++;
        end
      end
      sis_pkg::OP_WRITE: dur_mem[it.table_address] = it.table_value;
      sis_pkg::OP_START: begin
        // Restart the profile from entry 0; direction is kept.
        cur_index       = '0;
        counting_down   = 1'b0;
        now_us          = '0;
        interval_origin = '0;
        load_interval();
      end
      default: ;
    endcase
    res.direction      = dir_level;
    res.table_index    = cur_index;
    res.microstep_pins = pins_for(mode_q);
  endtask

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------
  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  task automatic check_result(input sis_pkg::out_item_t got);
    sis_pkg::out_item_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: result %h arrived with nothing expected", $time, got);
      error_count++;
    end else begin
      want = pending_results.pop_front();
      results_checked++;
      compare_field("step_pulse", want.step_pulse, got.step_pulse);
      compare_field("direction", want.direction, got.direction);
      compare_field("table_index", want.table_index, got.table_index);
      compare_field("interval_done", want.interval_done, got.interval_done);
      compare_field("microstep_pins", want.microstep_pins, got.microstep_pins);
    end
  endtask

  // Sample every handshake at the edge; all drivers use nonblocking updates,
  // so the values seen here are the ones the block saw.
  always @(posedge clk) begin
    sis_pkg::out_item_t predicted;
    if (rst_n && in_valid && in_ready) begin
      schedule_step(in_data, predicted);
      pending_results.push_back(drv_has_exp ? drv_exp : predicted);
      items_in++;
    end
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        sis_pkg::CFG_STEP_MODE:    mode_q       = cfg_data[2:0];
        sis_pkg::CFG_FULL_STEPS:   full_steps_q = cfg_data;
        sis_pkg::CFG_TABLE_LENGTH: length_q     = cfg_data[4:0];
        default: ;
      endcase
      reg_writes++;
    end
    if (rst_n && out_valid && out_ready) check_result(out_data);
  end

  // Watchdog: end the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, pending_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: random back-pressure, one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        // Hold off long enough that the block fills and stalls its input.
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      out_ready <= no_idle || ($urandom_range(99) >= 36);
      @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  typedef struct {
    bit                 is_cfg;
    sis_pkg::cfg_reg_t  reg_sel;
    logic [12:0]        reg_val;
    sis_pkg::in_item_t  item;
    bit                 has_exp;
  } plan_row_t;

  plan_row_t plan [$];

  // Register settings walked by the first random phases: extremes first.
  logic [2:0]  fixed_mode [8] = '{3'd0, 3'd4, 3'd7, 3'd5, 3'd1, 3'd3, 3'd2, 3'd6};
  logic [12:0] fixed_fsi  [8] = '{13'd1, 13'd4096, 13'd0, 13'd8191,
                                  13'd2, 13'd1, 13'd3, 13'd1};
  logic [4:0]  fixed_len  [8] = '{5'd16, 5'd16, 5'd0, 5'd31, 5'd17, 5'd5, 5'd1, 5'd16};

  function automatic sis_pkg::in_item_t make_item(input logic [1:0] op,
                                                  input logic [3:0] addr,
                                                  input logic [23:0] val);
    sis_pkg::in_item_t it;
    it.opcode        = op;
    it.table_address = addr;
    it.table_value   = val;
    return it;
  endfunction

  task automatic plan_op(input logic [1:0] op, input logic [3:0] addr,
                         input logic [23:0] val, input bit has_exp);
    plan_row_t row;
    row.is_cfg  = 1'b0;
    row.reg_sel = sis_pkg::CFG_STEP_MODE;
    row.reg_val = '0;
    row.item    = make_item(op, addr, val);
    row.has_exp = has_exp;
    plan.push_back(row);
  endtask

  task automatic plan_reg(input sis_pkg::cfg_reg_t sel, input logic [12:0] val);
    plan_row_t row;
    row.is_cfg  = 1'b1;
    row.reg_sel = sel;
    row.reg_val = val;
    row.item    = '0;
    row.has_exp = 1'b0;
    plan.push_back(row);
  endtask

  // Mostly short intervals so that interval ends come often.
  function automatic logic [23:0] pick_duration();
    if ($urandom_range(99) < 88) return 24'($urandom_range(0, 80));
    return 24'($urandom());
  endfunction

  function automatic sis_pkg::in_item_t random_item(input logic [1:0] op);
    return make_item(op, 4'($urandom_range(0, 15)),
                     op == sis_pkg::OP_WRITE ? pick_duration() : 24'($urandom()));
  endfunction

  // Offer one transaction; valid stays high until it is taken.
  task automatic offer(input sis_pkg::in_item_t it, input bit has_exp);
    if (!no_idle && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_data     <= it;
    in_valid    <= 1'b1;
    drv_has_exp <= has_exp;
    drv_exp     <= AFTER_RESET;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait until every expected result is back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller drops it after the last write.
  task automatic write_reg(input sis_pkg::cfg_reg_t sel, input logic [12:0] val);
    cfg_index <= sel;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input logic [2:0] mode, input logic [12:0] fsi,
                           input logic [4:0] len);
    wait_idle();
    write_reg(sis_pkg::CFG_STEP_MODE, 13'(mode));
    write_reg(sis_pkg::CFG_FULL_STEPS, fsi);
    write_reg(sis_pkg::CFG_TABLE_LENGTH, 13'(len));
    cfg_valid <= 1'b0;
  endtask

  // One random phase: new settings, usually a start, then mostly ticks
  // with the odd table write, restart or unused opcode mixed in.
  task automatic run_phase(input int unsigned ph);
    logic [2:0]  mode;
    logic [12:0] fsi;
    logic [4:0]  len;
    logic [1:0]  op;
    int unsigned roll;
    int unsigned ticks;
    if (ph < 8) begin
      mode = fixed_mode[ph];
      fsi  = fixed_fsi[ph];
      len  = fixed_len[ph];
    end else begin
      mode = 3'($urandom_range(0, 7));
      roll = $urandom_range(99);
      if (roll < 80)      fsi = 13'($urandom_range(1, 4));
      else if (roll < 90) fsi = 13'($urandom_range(0, 8191));
      else if (roll < 95) fsi = 13'd0;
      else                fsi = 13'd4096;
      len = ($urandom_range(99) < 85) ? 5'($urandom_range(1, 16)) : 5'($urandom_range(0, 31));
    end
    configure(mode, fsi, len);
    // A stretch of phases with no idling on either side.
    no_idle = (ph >= 12 && ph < 16);
    // Skipping the start keeps the old index, which may now lie past the length.
    if ($urandom_range(99) < 75) begin
      offer(random_item(sis_pkg::OP_START), 1'b0);
      random_sent++;
    end
    // Huge step counts never close an interval here; keep those phases short.
    ticks = (interval_steps(mode, fsi) > 64) ? $urandom_range(6, 12) : $urandom_range(15, 40);
    for (int unsigned k = 0; k < ticks; k++) begin
      if (ph == 6 && k == 4) hold_request = 1'b1;
      roll = $urandom_range(99);
      if (roll < 84)      op = sis_pkg::OP_TICK;
      else if (roll < 94) op = sis_pkg::OP_WRITE;
      else if (roll < 97) op = sis_pkg::OP_START;
      else                op = OP_UNUSED;
      offer(random_item(op), 1'b0);
      if (op != OP_UNUSED) random_sent++;
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    drv_has_exp = 1'b0;
    drv_exp     = AFTER_RESET;
    foreach (dur_mem[i]) dur_mem[i] = '0;

    // Directed part. Writes right after reset read back the reset levels.
    plan_op(sis_pkg::OP_WRITE, 4'd0, 24'd3, 1'b1);
    plan_op(sis_pkg::OP_WRITE, 4'd1, 24'hFFFFFF, 1'b1);
    plan_op(sis_pkg::OP_WRITE, 4'd15, 24'h000000, 1'b1);
    plan_op(OP_UNUSED, 4'd5, 24'hABCDEF, 1'b1);
    // Ticks before any start, two entries in use: the long second entry
    // pushes the due time to saturation and the origin ahead of the clock.
    plan_reg(sis_pkg::CFG_TABLE_LENGTH, 13'd2);
    plan_op(sis_pkg::OP_TICK, 4'd15, 24'hFFFFFF, 1'b0);
    plan_op(sis_pkg::OP_TICK, 4'd0, 24'h000000, 1'b0);
    // Length zero runs as one entry; the index now sits past it.
    plan_reg(sis_pkg::CFG_TABLE_LENGTH, 13'd0);
    plan_op(sis_pkg::OP_TICK, 4'd7, 24'h5A5A5A, 1'b0);
    plan_op(sis_pkg::OP_TICK, 4'd8, 24'hA5A5A5, 1'b0);
    plan_op(sis_pkg::OP_START, 4'd15, 24'hFFFFFF, 1'b0);
    plan_op(sis_pkg::OP_TICK, 4'd0, 24'h000000, 1'b0);
    plan_op(sis_pkg::OP_TICK, 4'd0, 24'h000000, 1'b0);
    plan_op(sis_pkg::OP_TICK, 4'd0, 24'h000000, 1'b0);
    plan_reg(sis_pkg::CFG_STEP_MODE, 13'd4);
    plan_op(sis_pkg::OP_WRITE, 4'd2, 24'h800000, 1'b0);
    plan_op(sis_pkg::OP_START, 4'd0, 24'h000000, 1'b0);
    plan_op(sis_pkg::OP_TICK, 4'd3, 24'h123456, 1'b0);
    plan_op(sis_pkg::OP_TICK, 4'd12, 24'hEDCBA9, 1'b0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_idle();
        write_reg(plan[i].reg_sel, plan[i].reg_val);
        cfg_valid <= 1'b0;
      end else begin
        offer(plan[i].item, plan[i].has_exp);
      end
    end

    // Fill every entry before the random phases can read any of them.
    for (int unsigned a = 0; a < TABLE_DEPTH; a++) begin
      offer(make_item(sis_pkg::OP_WRITE, 4'(a), pick_duration()), 1'b0);
      random_sent++;
    end
    while (random_sent < RANDOM_ITEMS) begin
      run_phase(phase_count);
      phase_count++;
    end

    // Drain, then give a late or extra result time to show up.
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d items, %0d results checked, %0d register writes, %0d phases",
             items_in, results_checked, reg_writes, phase_count);
    $display("Schedule went through %0d interval ends and %0d direction reversals",
             intervals_seen, reversals);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
